// ===== hw/rtl/bilinear_mask_texture_blend_core_assert.svh =====
// Assertion macros for the bilinear mask texture blend core.
`ifndef BILINEAR_MASK_TEXTURE_BLEND_CORE_ASSERT_SVH
`define BILINEAR_MASK_TEXTURE_BLEND_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define BMTB_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("bmtb assertion failed");
`define BMTB_ASSERT_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("bmtb assertion failed");
`else
`define BMTB_ASSERT(name, clk, rstn, prop)
`define BMTB_ASSERT_NEVER(name, clk, rstn, cond)
`endif

`endif

// ===== hw/rtl/bmtb_pkg.sv =====
// Types, constants and arithmetic helpers of the bilinear mask texture blend core.
`default_nettype none

package bmtb_pkg;

  localparam int unsigned MASK_DIM_DEF   = 128;
  localparam int unsigned COORD_BITS_DEF = 12;

  localparam int unsigned STEP_W     = 24;
  localparam int unsigned REGION_W   = 13;
  localparam int unsigned CELL_W     = 7;
  localparam int unsigned WEIGHT_W   = 9;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned FRAC_SHIFT = 16;
  localparam int unsigned ROW_W      = 17;
  localparam int unsigned MAG_W      = 25;
  localparam int unsigned MIX_W      = CHAN_W + MAG_W + 2;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE     = 9'd256;
  localparam logic [STEP_W-1:0]   STEP_RST       = 24'd65536;
  localparam logic [REGION_W-1:0] REGION_RST     = 13'd1;
  localparam logic [CELL_W-1:0]   CELL_LIMIT_RST = 7'd99;

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_X     = 3'd0,
    CFG_STEP_Y     = 3'd1,
    CFG_REGION_W   = 3'd2,
    CFG_REGION_H   = 3'd3,
    CFG_CELL_LIMIT = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_CHK,
    S_RD00,
    S_RD10,
    S_RD01,
    S_RD11,
    S_LERPX,
    S_LERPY,
    S_NEAR,
    S_MIX
  } state_e;

  typedef struct packed {
    opcode_e             opcode;
    logic [CELL_W-1:0]   mask_col;
    logic [CELL_W-1:0]   mask_row;
    logic [WEIGHT_W-1:0] mask_value;
    logic [COORD_W-1:0]  pix_col;
    logic [COORD_W-1:0]  pix_row;
    logic [CHAN_W-1:0]   dst_r;
    logic [CHAN_W-1:0]   dst_g;
    logic [CHAN_W-1:0]   dst_b;
    logic [CHAN_W-1:0]   src_r;
    logic [CHAN_W-1:0]   src_g;
    logic [CHAN_W-1:0]   src_b;
  } in_beat_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_r;
    logic [CHAN_W-1:0] out_g;
    logic [CHAN_W-1:0] out_b;
    logic              blended;
  } out_beat_t;

  // w0 * (256 - f) + w1 * f
  function automatic logic [ROW_W-1:0] lerp_row(input logic [WEIGHT_W-1:0] w0,
                                                input logic [WEIGHT_W-1:0] w1,
                                                input logic [FRAC_W-1:0]   f);
    logic [WEIGHT_W-1:0] inv;
    inv = WEIGHT_ONE - WEIGHT_W'(f);
    return ROW_W'(ROW_W'(w0) * ROW_W'(inv)) + ROW_W'(ROW_W'(w1) * ROW_W'(f));
  endfunction

  // m0 * (256 - f) + m1 * f
  function automatic logic [MAG_W-1:0] lerp_col(input logic [ROW_W-1:0]  m0,
                                                input logic [ROW_W-1:0]  m1,
                                                input logic [FRAC_W-1:0] f);
    logic [WEIGHT_W-1:0] inv;
    inv = WEIGHT_ONE - WEIGHT_W'(f);
    return MAG_W'(MAG_W'(m0) * MAG_W'(inv)) + MAG_W'(MAG_W'(m1) * MAG_W'(f));
  endfunction

  // dst + floor((src - dst) * mag / 2^24), exact against the two-product form
  function automatic logic [CHAN_W-1:0] mix_chan(input logic [CHAN_W-1:0] src,
                                                 input logic [CHAN_W-1:0] dst,
                                                 input logic [MAG_W-1:0]  mag);
    logic signed [CHAN_W:0]  diff;
    logic signed [MIX_W-1:0] prod;
    diff = $signed({1'b0, src}) - $signed({1'b0, dst});
    prod = MIX_W'(diff) * MIX_W'($signed({1'b0, mag}));
    return dst + prod[31:24];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bmtb_chan_if.sv =====
// Valid/ready channel carrying one beat of a given payload type.
`default_nettype none

interface bmtb_chan_if #(
  parameter type beat_t = logic
);
  logic  valid;
  logic  ready;
  beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bilinear_mask_texture_blend_core.sv =====
// Bilinear masked alpha blend core: mask memory, interpolation and RGB blend.
//
// Channels: in_i takes load beats (opcode load: write one mask weight, values
// above 1.0 saturate) and pixel beats (opcode pixel: column, row, dst and src
// RGB). out_o returns one beat per pixel beat, none per load beat. Beats move
// when valid and ready are both high. cfg_we_i writes register cfg_idx_i with
// cfg_data_i at the clock edge; write only while the core is idle.
// A load beat leaves the core idle. A pixel beat runs S_MUL and S_CHK, then
// S_RD00 through S_LERPY when interpolating, S_RD00 and S_NEAR on the last
// region row or column, nothing when the cell is out of range, then S_MIX;
// the next beat is accepted in the cycle after the result is registered.
// The mask has one read port, so the four neighbor weights are read in turn.
// Reset restores the register defaults; the mask contents are undefined
// until loaded and are not cleared. A stalled receiver holds the result in
// the output register; the core still takes load beats and one more pixel
// beat, and then waits until the result register frees up.
`default_nettype none
`include "bilinear_mask_texture_blend_core_assert.svh"

module bilinear_mask_texture_blend_core #(
  parameter int unsigned MASK_DIM   = bmtb_pkg::MASK_DIM_DEF,
  parameter int unsigned COORD_BITS = bmtb_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bmtb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bmtb_pkg::STEP_W-1:0]    cfg_data_i,
  bmtb_chan_if.sink                      in_i,
  bmtb_chan_if.source                    out_o
);
  import bmtb_pkg::*;

  localparam int unsigned IDX_W       = $clog2(MASK_DIM);
  localparam int unsigned RECIP_SHIFT = 17;
  localparam int unsigned RECIP       = ((1 << RECIP_SHIFT) + MASK_DIM - 1) / MASK_DIM;
  localparam int unsigned PROD_W      = COORD_W + STEP_W;
  localparam int unsigned IX_W        = PROD_W - FRAC_SHIFT;
  localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((64'd1 << COORD_BITS) - 64'd1);
  localparam logic [PROD_W-1:0]  CELL_BIAS  = PROD_W'(2) << FRAC_SHIFT;

  // v mod MASK_DIM for v below 128, by reciprocal multiply
  function automatic logic [IDX_W-1:0] mod_dim(input logic [CELL_W-1:0] v);
    logic [23:0]       prod;
    logic [CELL_W-1:0] quo;
    logic [15:0]       back;
    prod = 24'(v) * 24'(RECIP);
    quo  = CELL_W'(prod >> RECIP_SHIFT);
    back = 16'(quo) * 16'(MASK_DIM);
    return IDX_W'(16'(v) - back);
  endfunction

  // configuration
  logic [STEP_W-1:0]   step_x_q, step_y_q;
  logic [REGION_W-1:0] region_w_q, region_h_q;
  logic [CELL_W-1:0]   cell_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_x_q     <= STEP_RST;
      step_y_q     <= STEP_RST;
      region_w_q   <= REGION_RST;
      region_h_q   <= REGION_RST;
      cell_limit_q <= CELL_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_STEP_X:     step_x_q     <= cfg_data_i;
        CFG_STEP_Y:     step_y_q     <= cfg_data_i;
        CFG_REGION_W:   region_w_q   <= cfg_data_i[REGION_W-1:0];
        CFG_REGION_H:   region_h_q   <= cfg_data_i[REGION_W-1:0];
        CFG_CELL_LIMIT: cell_limit_q <= cfg_data_i[CELL_W-1:0];
        default: ;
      endcase
    end
  end

  // control
  state_e state_q, state_d;
  logic   out_valid_q;
  logic   in_fire, mix_fire;
  logic   in_range, interp_d, interp_q;

  in_beat_t  item_q;
  out_beat_t out_q;

  logic [PROD_W-1:0]   cx_q, cy_q;
  logic [IX_W-1:0]     ix, iy;
  logic [COORD_W-1:0]  px, py;
  logic [FRAC_W-1:0]   fx_q, fy_q;
  logic [IDX_W-1:0]    c0_q, c1_q, r0_q, r1_q;
  logic [IDX_W-1:0]    rd_c, rd_r;
  logic [WEIGHT_W-1:0] rdata_q, w00_q, w01_q, wr_val;
  logic [ROW_W-1:0]    m0_q, m1_q;
  logic [MAG_W-1:0]    mag_q;

  logic [WEIGHT_W-1:0] mask_mem [MASK_DIM][MASK_DIM];

  assign px = item_q.pix_col & COORD_MASK;
  assign py = item_q.pix_row & COORD_MASK;
  assign ix = cx_q[PROD_W-1:FRAC_SHIFT];
  assign iy = cy_q[PROD_W-1:FRAC_SHIFT];
  assign in_range = (ix < IX_W'(cell_limit_q)) && (iy < IX_W'(cell_limit_q));
  assign interp_d = (({1'b0, px} + REGION_W'(1)) < region_w_q) &&
                    (({1'b0, py} + REGION_W'(1)) < region_h_q);
  assign wr_val = (in_i.data.mask_value > WEIGHT_ONE) ? WEIGHT_ONE : in_i.data.mask_value;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire && in_i.data.opcode == OP_PIXEL) state_d = S_MUL;
      S_MUL:   state_d = S_CHK;
      S_CHK:   state_d = in_range ? S_RD00 : S_MIX;
      S_RD00:  state_d = interp_q ? S_RD10 : S_NEAR;
      S_RD10:  state_d = S_RD01;
      S_RD01:  state_d = S_RD11;
      S_RD11:  state_d = S_LERPX;
      S_LERPX: state_d = S_LERPY;
      S_LERPY: state_d = S_MIX;
      S_NEAR:  state_d = S_MIX;
      S_MIX:   if (mix_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = (state_q == S_IDLE);
    in_fire    = in_i.valid && (state_q == S_IDLE);
    mix_fire   = (state_q == S_MIX) && (!out_valid_q || out_o.ready);
    rd_c       = c0_q;
    rd_r       = r0_q;
    unique case (state_q)
      S_RD10:  rd_c = c1_q;
      S_RD01:  rd_r = r1_q;
      S_RD11: begin
        rd_c = c1_q;
        rd_r = r1_q;
      end
      default: ;
    endcase
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mix_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // mask memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (in_fire && in_i.data.opcode == OP_LOAD) begin
      mask_mem[mod_dim(in_i.data.mask_col)][mod_dim(in_i.data.mask_row)] <= wr_val;
    end
    rdata_q <= mask_mem[rd_c][rd_r];
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_i.data;
    end
    unique case (state_q)
      S_MUL: begin
        cx_q <= PROD_W'(PROD_W'(px) * PROD_W'(step_x_q)) + CELL_BIAS;
        cy_q <= PROD_W'(PROD_W'(py) * PROD_W'(step_y_q)) + CELL_BIAS;
      end
      S_CHK: begin
        interp_q <= interp_d;
        fx_q     <= cx_q[FRAC_SHIFT-1 -: FRAC_W];
        fy_q     <= cy_q[FRAC_SHIFT-1 -: FRAC_W];
        c0_q     <= mod_dim(ix[CELL_W-1:0]);
        c1_q     <= mod_dim(ix[CELL_W-1:0] + CELL_W'(1));
        r0_q     <= mod_dim(iy[CELL_W-1:0]);
        r1_q     <= mod_dim(iy[CELL_W-1:0] + CELL_W'(1));
        if (!in_range) begin
          mag_q <= '0;
        end
      end
      S_RD10:  w00_q <= rdata_q;
      S_RD01:  m0_q  <= lerp_row(w00_q, rdata_q, fx_q);
      S_RD11:  w01_q <= rdata_q;
      S_LERPX: m1_q  <= lerp_row(w01_q, rdata_q, fx_q);
      S_LERPY: mag_q <= lerp_col(m0_q, m1_q, fy_q);
      S_NEAR:  mag_q <= {rdata_q, 16'b0};
      default: ;
    endcase
    if (mix_fire) begin
      out_q.out_r   <= mix_chan(item_q.src_r, item_q.dst_r, mag_q);
      out_q.out_g   <= mix_chan(item_q.src_g, item_q.dst_g, mag_q);
      out_q.out_b   <= mix_chan(item_q.src_b, item_q.dst_b, mag_q);
      out_q.blended <= (mag_q != '0);
    end
  end

  `BMTB_ASSERT(a_pixel_starts, clk_i, rst_ni, (in_fire && in_i.data.opcode == OP_PIXEL) |=> (state_q == S_MUL))
  `BMTB_ASSERT(a_load_stays_idle, clk_i, rst_ni, (in_fire && in_i.data.opcode == OP_LOAD) |=> (state_q == S_IDLE))
  `BMTB_ASSERT(a_mix_gives_beat, clk_i, rst_ni, mix_fire |=> (out_valid_q && state_q == S_IDLE))
  `BMTB_ASSERT(a_zero_weight_passes, clk_i, rst_ni, (mix_fire && mag_q == '0) |=> !out_q.blended)
  `BMTB_ASSERT_NEVER(a_near_only_on_edge, clk_i, rst_ni, state_q == S_NEAR && interp_q)

endmodule

`default_nettype wire

// ===== tb/blend_checker.sv =====
// Checker for the bilinear mask blend core: mirrors mask and registers, predicts pixels.
module blend_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bmtb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bmtb_pkg::STEP_W-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  bmtb_pkg::in_beat_t             in_beat_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  bmtb_pkg::out_beat_t            out_beat_i,
  output int                             pending_o,
  output int                             errors_o
);
  import bmtb_pkg::*;

  localparam logic [63:0] UNIT_Q24 = 64'd1 << 24;

  logic [STEP_W-1:0]   step_x;
  logic [STEP_W-1:0]   step_y;
  logic [REGION_W-1:0] region_w;
  logic [REGION_W-1:0] region_h;
  logic [CELL_W-1:0]   cell_lim;
  logic [WEIGHT_W-1:0] weight_grid [MASK_DIM_DEF][MASK_DIM_DEF];
  out_beat_t           expected_pixels [$];
  int                  errors;

  function automatic logic [CHAN_W-1:0] mix_channel(input logic [CHAN_W-1:0] src,
                                                    input logic [CHAN_W-1:0] dst,
                                                    input logic [63:0]       mag);
    logic [63:0] acc;
    acc = (64'(src) * mag + 64'(dst) * (UNIT_Q24 - mag)) >> 24;
    return acc[CHAN_W-1:0];
  endfunction

  function automatic out_beat_t predict_pixel(input in_beat_t b);
    logic [63:0]       cx, cy, fx, fy, m0, m1, mag;
    logic [CELL_W-1:0] c0, c1, r0, r1;
    out_beat_t         res;
    cx = 64'(b.pix_col) * 64'(step_x) + (64'd2 << FRAC_SHIFT);
    cy = 64'(b.pix_row) * 64'(step_y) + (64'd2 << FRAC_SHIFT);
    fx = (cx >> 8) & 64'hFF;
    fy = (cy >> 8) & 64'hFF;
    res.out_r   = b.dst_r;
    res.out_g   = b.dst_g;
    res.out_b   = b.dst_b;
    res.blended = 1'b0;
    if ((cx >> FRAC_SHIFT) >= 64'(cell_lim) || (cy >> FRAC_SHIFT) >= 64'(cell_lim))
      return res;
    c0 = cx[FRAC_SHIFT +: CELL_W];
    r0 = cy[FRAC_SHIFT +: CELL_W];
    c1 = c0 + CELL_W'(1);
    r1 = r0 + CELL_W'(1);
    if (64'(b.pix_col) + 1 < 64'(region_w) && 64'(b.pix_row) + 1 < 64'(region_h)) begin
      m0  = 64'(weight_grid[c0][r0]) * (64'd256 - fx) + 64'(weight_grid[c1][r0]) * fx;
      m1  = 64'(weight_grid[c0][r1]) * (64'd256 - fx) + 64'(weight_grid[c1][r1]) * fx;
      mag = m0 * (64'd256 - fy) + m1 * fy;
    end else begin
      mag = 64'(weight_grid[c0][r0]) << 16;
    end
    if (mag > UNIT_Q24)
      mag = UNIT_Q24;
    if (mag != 0) begin
      res.out_r   = mix_channel(b.src_r, b.dst_r, mag);
      res.out_g   = mix_channel(b.src_g, b.dst_g, mag);
      res.out_b   = mix_channel(b.src_b, b.dst_b, mag);
      res.blended = 1'b1;
    end
    return res;
  endfunction

  function automatic int check_field(input string name, input logic [7:0] want,
                                     input logic [7:0] got);
    if (want === got)
      return 0;
    $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      step_x    = STEP_RST;
      step_y    = STEP_RST;
      region_w  = REGION_RST;
      region_h  = REGION_RST;
      cell_lim  = CELL_LIMIT_RST;
      errors    = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_STEP_X:     step_x   = cfg_data_i;
          CFG_STEP_Y:     step_y   = cfg_data_i;
          CFG_REGION_W:   region_w = cfg_data_i[REGION_W-1:0];
          CFG_REGION_H:   region_h = cfg_data_i[REGION_W-1:0];
          CFG_CELL_LIMIT: cell_lim = cfg_data_i[CELL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (in_beat_i.opcode == OP_LOAD) begin
          weight_grid[in_beat_i.mask_col][in_beat_i.mask_row] =
            (in_beat_i.mask_value > WEIGHT_ONE) ? WEIGHT_ONE : in_beat_i.mask_value;
        end else begin
          expected_pixels.push_back(predict_pixel(in_beat_i));
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: pixel beat expected none actual %h", $time, out_beat_i);
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          errors += check_field("out_r", want.out_r, out_beat_i.out_r);
          errors += check_field("out_g", want.out_g, out_beat_i.out_g);
          errors += check_field("out_b", want.out_b, out_beat_i.out_b);
          errors += check_field("blended", 8'(want.blended), 8'(out_beat_i.blended));
        end
      end
      pending_o <= expected_pixels.size();
      errors_o  <= errors;
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the blend core bench: clock, reset, load and pixel stimulus, verdict.
module testbench;
  import bmtb_pkg::*;

  localparam int ITEM_TOTAL = 1700;
  localparam int CALM_AFTER = 1450;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [STEP_W-1:0]    cfg_data;
  int                   pending;
  int                   errors;

  bit                   idle_on;
  int                   beats_sent;
  bit                   cell_loaded [MASK_DIM_DEF][MASK_DIM_DEF];
  logic [STEP_W-1:0]    sh_step_x;
  logic [STEP_W-1:0]    sh_step_y;
  logic [REGION_W-1:0]  sh_w;
  logic [REGION_W-1:0]  sh_h;
  logic [CELL_W-1:0]    sh_lim;

  bmtb_chan_if #(.beat_t(in_beat_t))  pix_in ();
  bmtb_chan_if #(.beat_t(out_beat_t)) pix_out ();

  bilinear_mask_texture_blend_core uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (pix_in),
    .out_o      (pix_out)
  );

  blend_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (pix_in.valid),
    .in_ready_i  (pix_in.ready),
    .in_beat_i   (pix_in.data),
    .out_valid_i (pix_out.valid),
    .out_ready_i (pix_out.ready),
    .out_beat_i  (pix_out.data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver stalls
  initial begin
    pix_out.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (idle_on && beats_sent < CALM_AFTER && $urandom_range(0, 7) == 0) begin
        pix_out.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      pix_out.ready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic in_beat_t random_beat();
    return in_beat_t'({$urandom(), $urandom(), $urandom()});
  endfunction

  function automatic logic [WEIGHT_W-1:0] random_weight();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return WEIGHT_ONE;
      2:       return WEIGHT_W'($urandom_range(257, 511));
      default: return WEIGHT_W'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return STEP_RST;
      default: return STEP_W'($urandom_range(24'h000800, 24'h030000));
    endcase
  endfunction

  function automatic logic [REGION_W-1:0] pick_extent();
    case ($urandom_range(0, 7))
      0:       return REGION_RST;
      1:       return REGION_W'(4096);
      2:       return REGION_W'($urandom_range(0, 8191));
      default: return REGION_W'($urandom_range(2, 300));
    endcase
  endfunction

  function automatic logic [CELL_W-1:0] pick_limit();
    case ($urandom_range(0, 7))
      0:       return CELL_W'(127);
      1:       return CELL_W'($urandom_range(0, 3));
      default: return CELL_W'($urandom_range(4, 127));
    endcase
  endfunction

  // mostly coordinates that land inside the mask, some on the region edge, some anywhere
  function automatic logic [COORD_W-1:0] pick_coord(input logic [STEP_W-1:0]   step,
                                                    input logic [REGION_W-1:0] extent,
                                                    input logic [CELL_W-1:0]   lim);
    logic [63:0] span;
    int          v;
    if (lim <= 2)
      span = 0;
    else
      span = (((64'(lim) - 2) << 16) - 1) / ((step == 0) ? 64'd1 : 64'(step));
    if (span > 4095)
      span = 4095;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        v = $urandom_range(0, int'(span));
        if (extent >= 2 && v + 1 >= int'(extent) && $urandom_range(0, 1) == 1)
          v = $urandom_range(0, (int'(span) < int'(extent) - 2) ? int'(span)
                                                               : int'(extent) - 2);
      end
      6, 7: begin
        v = int'(extent) - 1 - int'($urandom_range(0, 1));
        if (v < 0)
          v = 0;
        if (v > 4095)
          v = 4095;
      end
      default: v = $urandom_range(0, 4095);
    endcase
    return COORD_W'(v);
  endfunction

  task automatic send_beat(input in_beat_t b);
    if (idle_on && beats_sent < CALM_AFTER && $urandom_range(0, 9) == 0) begin
      pix_in.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.data  <= b;
    do @(posedge clk); while (!pix_in.ready);
    beats_sent++;
  endtask

  task automatic load_cell(input logic [CELL_W-1:0] col, input logic [CELL_W-1:0] row,
                           input logic [WEIGHT_W-1:0] value);
    in_beat_t b;
    b            = random_beat();
    b.opcode     = OP_LOAD;
    b.mask_col   = col;
    b.mask_row   = row;
    b.mask_value = value;
    cell_loaded[col][row] = 1'b1;
    send_beat(b);
  endtask

  // loads any mask cell the pixel would read that has never been written
  task automatic send_pixel(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                            input logic [47:0] colors);
    logic [63:0]       cx, cy;
    logic [CELL_W-1:0] c, r;
    int                reach, dx, dy;
    in_beat_t          b;
    cx = 64'(px) * 64'(sh_step_x) + (64'd2 << FRAC_SHIFT);
    cy = 64'(py) * 64'(sh_step_y) + (64'd2 << FRAC_SHIFT);
    if ((cx >> FRAC_SHIFT) < 64'(sh_lim) && (cy >> FRAC_SHIFT) < 64'(sh_lim)) begin
      reach = (int'(px) + 1 < int'(sh_w) && int'(py) + 1 < int'(sh_h)) ? 1 : 0;
      for (dx = 0; dx <= reach; dx++) begin
        for (dy = 0; dy <= reach; dy++) begin
          c = cx[FRAC_SHIFT +: CELL_W] + CELL_W'(dx);
          r = cy[FRAC_SHIFT +: CELL_W] + CELL_W'(dy);
          if (!cell_loaded[c][r])
            load_cell(c, r, random_weight());
        end
      end
    end
    b         = random_beat();
    b.opcode  = OP_PIXEL;
    b.pix_col = px;
    b.pix_row = py;
    b[47:0]   = colors;
    send_beat(b);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [STEP_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [STEP_W-1:0] sx, input logic [STEP_W-1:0] sy,
                              input logic [REGION_W-1:0] w, input logic [REGION_W-1:0] h,
                              input logic [CELL_W-1:0] lim);
    write_reg(CFG_STEP_X, sx);
    write_reg(CFG_STEP_Y, sy);
    write_reg(CFG_REGION_W, STEP_W'(w));
    write_reg(CFG_REGION_H, STEP_W'(h));
    write_reg(CFG_CELL_LIMIT, STEP_W'(lim));
    cfg_we    <= 1'b0;
    sh_step_x = sx;
    sh_step_y = sy;
    sh_w      = w;
    sh_h      = h;
    sh_lim    = lim;
  endtask

  // hold off the sender until every pixel is back, then let loads settle
  task automatic drain();
    pix_in.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  initial begin
    int phase_start;
    pix_in.valid <= 1'b0;
    pix_in.data  <= '0;
    cfg_we       <= 1'b0;
    cfg_idx      <= CFG_STEP_X;
    cfg_data     <= '0;
    rst_n        <= 1'b0;
    idle_on      = 1'b1;
    beats_sent   = 0;
    sh_step_x    = STEP_RST;
    sh_step_y    = STEP_RST;
    sh_w         = REGION_RST;
    sh_h         = REGION_RST;
    sh_lim       = CELL_LIMIT_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: 1x1 region, nearest cell wherever the cell is in range
    load_cell(7'd0, 7'd0, 9'd0);
    load_cell(7'd127, 7'd127, 9'd511);
    load_cell(7'd127, 7'd0, 9'd257);
    load_cell(7'd0, 7'd127, 9'd256);
    load_cell(7'd2, 7'd2, 9'd256);
    load_cell(7'd3, 7'd2, 9'd128);
    load_cell(7'd2, 7'd3, 9'd0);
    send_pixel(12'd0, 12'd0, 48'h000000_FFFFFF);
    send_pixel(12'd1, 12'd0, 48'hFFFFFF_000000);
    send_pixel(12'd0, 12'd1, 48'h123456_ABCDEF);
    send_pixel(12'd97, 12'd0, 48'h00FF00_FF00FF);
    send_pixel(12'd4095, 12'd4095, 48'hFFFFFF_FFFFFF);
    drain();

    // interpolation over a full region
    apply_config(24'h008000, 24'h004000, 13'd4096, 13'd4096, 7'd127);
    send_pixel(12'd0, 12'd0, 48'h000000_FFFFFF);
    send_pixel(12'd1, 12'd3, 48'hFFFFFF_000000);
    send_pixel(12'd249, 12'd0, 48'h80FF01_7F00FE);
    send_pixel(12'd4094, 12'd100, 48'h0F0F0F_F0F0F0);
    send_pixel(12'd4095, 12'd4095, 48'hFFFFFF_000000);
    drain();

    // zero width region, extreme steps
    apply_config(24'h000000, 24'hFFFFFF, 13'd0, 13'd8191, 7'd127);
    send_pixel(12'd4095, 12'd0, 48'h000000_FFFFFF);
    send_pixel(12'd0, 12'd1, 48'hFFFFFF_000000);
    drain();

    // zero cell limit passes everything
    apply_config(STEP_RST, STEP_RST, 13'd4096, 13'd4096, 7'd0);
    send_pixel(12'd0, 12'd0, 48'h000000_FFFFFF);
    drain();

    while (beats_sent < ITEM_TOTAL) begin
      idle_on = ($urandom_range(0, 4) != 0);
      apply_config(pick_step(), pick_step(), pick_extent(), pick_extent(), pick_limit());
      phase_start = beats_sent;
      while (beats_sent - phase_start < 150 && beats_sent < ITEM_TOTAL) begin
        if ($urandom_range(0, 3) == 0)
          load_cell(CELL_W'($urandom()), CELL_W'($urandom()), random_weight());
        else
          send_pixel(pick_coord(sh_step_x, sh_w, sh_lim), pick_coord(sh_step_y, sh_h, sh_lim),
                     48'({$urandom(), $urandom()}));
      end
      drain();
    end

    idle_on = 1'b0;
    drain();
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
